[hw/rtl/assert_macros.svh]
// Assertion helper macros for the RTL modules.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/dccs_pkg.sv]
// Shared constants, codes and types for the curvature-clipped step block.
// No dependencies.
`default_nettype none

package dccs_pkg;

   // field widths
   localparam int unsigned IDX_W      = 12;
   localparam int unsigned SMP_W      = 33;
   localparam int unsigned CURV_W     = 32;
   localparam int unsigned DECAY_W    = 16;
   localparam int unsigned FLOOR_W    = 23;
   localparam int unsigned STEP_W     = 32;
   localparam int unsigned ACT_W      = 13;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // divider: one quotient bit per stage
   localparam int unsigned DIV_STEPS  = CURV_W;
   localparam int unsigned NUM_W      = 2 * DIV_STEPS;

   localparam int unsigned DEPTH_DEFAULT = 4096;

   // register reset values
   localparam logic [ACT_W-1:0]   ACTIVE_RESET = 13'd4096;
   localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd64881;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET  = 23'd655;
   localparam logic [STEP_W-1:0]  STEP_RESET   = 32'd16777;

   // item kinds
   localparam logic KIND_FOLD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ACTIVE_COUNT = 2'd0,
      REG_DECAY        = 2'd1,
      REG_FLOOR        = 2'd2,
      REG_STEP_SIZE    = 2'd3
   } csr_reg_type;

   // how the step magnitude is formed
   typedef enum logic [1:0] {
      MODE_ZERO = 2'd0,
      MODE_SAT  = 2'd1,
      MODE_DIV  = 2'd2
   } step_mode_type;

   // item data carried alongside the divider
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [CURV_W-1:0] curv;
      logic              status;
      logic              is_step;
      logic              neg;
      step_mode_type     mode;
   } meta_type;

endpackage

`default_nettype wire

[hw/rtl/dccs_ifs.sv]
// Valid/ready channel interfaces: item input, result output, register writes.
// Depends on dccs_pkg.
`default_nettype none

interface dccs_req_if;
   import dccs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [IDX_W-1:0]        index;
   logic signed [SMP_W-1:0] sample;

   modport source (output valid, kind, index, sample, input ready);
   modport sink   (input valid, kind, index, sample, output ready);
endinterface

interface dccs_rsp_if;
   import dccs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        index_echo;
   logic signed [SMP_W-1:0] step_value;
   logic [CURV_W-1:0]       curvature;
   logic                    status;

   modport source (output valid, index_echo, step_value, curvature, status, input ready);
   modport sink   (input valid, index_echo, step_value, curvature, status, output ready);
endinterface

interface dccs_csr_if;
   import dccs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/dccs_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on dccs_pkg. Numerator's upper half must be below the divisor.
`default_nettype none

module dccs_divider (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [dccs_pkg::NUM_W-1:0]  in_num,
   input  wire logic [dccs_pkg::CURV_W-1:0] in_den,
   input  wire dccs_pkg::meta_type      in_meta,
   output logic                         out_valid,
   output logic [dccs_pkg::CURV_W-1:0]  out_quo,
   output dccs_pkg::meta_type           out_meta
);
   import dccs_pkg::*;

   logic              vld_ff  [0:DIV_STEPS];
   logic [NUM_W-1:0]  acc_ff  [0:DIV_STEPS];
   logic [CURV_W-1:0] den_ff  [0:DIV_STEPS];
   meta_type          meta_ff [0:DIV_STEPS];

   // stage 0 captures the operands
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         meta_ff[0] <= in_meta;
      end
   end

   // one trial subtract per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [CURV_W:0]   trial;
      logic              ge;
      logic [CURV_W:0]   rem;
      logic [NUM_W-1:0]  acc_in;

      always_comb begin
         trial  = acc_ff[k][NUM_W-1:CURV_W-1];
         ge     = (trial >= {1'b0, den_ff[k]});
         rem    = ge ? (trial - {1'b0, den_ff[k]}) : trial;
         acc_in = {rem[CURV_W-1:0], acc_ff[k][CURV_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k+1]  <= acc_in;
            den_ff[k+1]  <= den_ff[k];
            meta_ff[k+1] <= meta_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS];
   assign out_quo   = acc_ff[DIV_STEPS][CURV_W-1:0];
   assign out_meta  = meta_ff[DIV_STEPS];

endmodule

`default_nettype wire

[hw/rtl/diagonal_curvature_clipped_step.sv]
// An accepted item passes stages 1 to 3, the divider stages and an output slot
// before its result is offered. Throughput: one item per cycle; an item that hits
// the entry of a fold still in stage 1 waits until that fold moves on (fold result
// is written back from the second stage). The whole pipeline holds while both
// output slots are full. Reset: registers take their defaults, then a clearing pass
// of one entry per cycle zeroes min(DEPTH,4096) entries; no item is taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module diagonal_curvature_clipped_step #(
   parameter int unsigned DEPTH = dccs_pkg::DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dccs_req_if.sink   req_chan,
   dccs_rsp_if.source rsp_chan,
   dccs_csr_if.sink   csr_chan
);
   import dccs_pkg::*;

   localparam int unsigned MEM_DEPTH = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
   localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [SMP_W-1:0]  step;
      logic [CURV_W-1:0] curv;
      logic              status;
   } rsp_type;

   // configuration registers
   logic [ACT_W-1:0]   active_count_ff;
   logic [DECAY_W-1:0] decay_ff;
   logic [FLOOR_W-1:0] floor_ff;
   logic [STEP_W-1:0]  step_size_ff;

   // clearing pass
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   // curvature store
   logic [CURV_W-1:0] mem [0:MEM_DEPTH-1];
   logic [CURV_W-1:0] rdata_ff;

   // stage 1: store read returns
   logic              s1_valid_ff;
   logic              s1_kind_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [SMP_W-1:0]  s1_sample_ff;
   logic              s1_ok_ff;
   logic              s1_wr;
   logic              s1_fwd;
   logic [CURV_W-1:0] s1_old;
   logic [CURV_W-1:0] s1_value;
   logic [DECAY_W:0]  s1_weight;
   logic [47:0]       s1_p1;
   logic [48:0]       s1_p2;

   // stage 2: fold sum and step setup
   logic              s2_valid_ff;
   logic              s2_kind_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [SMP_W-1:0]  s2_sample_ff;
   logic              s2_ok_ff;
   logic              s2_wr_ff;
   logic [CURV_W-1:0] s2_old_ff;
   logic [47:0]       s2_p1_ff;
   logic [48:0]       s2_p2_ff;
   logic [49:0]       s2_sum;
   logic [CURV_W-1:0] s2_new;
   logic              s2_neg;
   logic [SMP_W-1:0]  s2_mag;
   logic [CURV_W-1:0] s2_floor;
   logic [CURV_W-1:0] s2_hmax;
   logic [CURV_W-1:0] s2_h;
   step_mode_type     s2_mode;
   logic [CURV_W-1:0] s2_curv;

   // stage 3: product into divider
   logic              s3_valid_ff;
   logic [IDX_W-1:0]  s3_idx_ff;
   logic              s3_wr_ff;
   logic              s3_ok_ff;
   logic              s3_kind_ff;
   logic [CURV_W-1:0] s3_curv_ff;
   logic              s3_neg_ff;
   step_mode_type     s3_mode_ff;
   logic [CURV_W-1:0] s3_mag_ff;
   logic [CURV_W-1:0] s3_h_ff;
   logic [NUM_W-1:0]  s3_num;
   meta_type          s3_meta;

   // divider output and result forming
   logic              dv_valid;
   logic [CURV_W-1:0] dv_quo;
   meta_type          dv_meta;
   logic [CURV_W-1:0] res_mag;
   rsp_type           res;

   // output slots
   rsp_type     skid_ff [0:1];
   logic [1:0]  skid_cnt_ff;
   logic        skid_wr_ff;
   logic        skid_rd_ff;
   logic        push;
   logic        pop;

   logic adv;
   logic hazard;
   logic req_acc;
   logic in_range;

   // pipeline moves while an output slot is free
   assign adv     = (skid_cnt_ff != 2'd2);
   assign hazard  = s1_wr && (s1_idx_ff == req_chan.index);
   assign req_chan.ready = adv && !clr_busy_ff && !hazard;
   assign req_acc = req_chan.valid && req_chan.ready;
   assign in_range = (ACT_W'(req_chan.index) < active_count_ff) &&
                     (32'(req_chan.index) < 32'(DEPTH));

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= ACTIVE_RESET;
         decay_ff        <= DECAY_RESET;
         floor_ff        <= FLOOR_RESET;
         step_size_ff    <= STEP_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_reg_type'(csr_chan.addr))
            REG_ACTIVE_COUNT: active_count_ff <= csr_chan.data[ACT_W-1:0];
            REG_DECAY:        decay_ff        <= csr_chan.data[DECAY_W-1:0];
            REG_FLOOR:        floor_ff        <= csr_chan.data[FLOOR_W-1:0];
            REG_STEP_SIZE:    step_size_ff    <= csr_chan.data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(MEM_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (adv && s2_valid_ff && s2_wr_ff) begin
         mem[s2_idx_ff[AW-1:0]] <= s2_new;
      end
      if (req_acc) begin
         rdata_ff <= mem[req_chan.index[AW-1:0]];
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff   <= req_chan.kind;
         s1_idx_ff    <= req_chan.index;
         s1_sample_ff <= req_chan.sample;
         s1_ok_ff     <= in_range;
      end
   end

   // stage 1: forward the fold written back at the same edge as the store read, then weight products
   always_comb begin
      s1_wr     = s1_valid_ff && (s1_kind_ff == KIND_FOLD) && s1_ok_ff;
      s1_fwd    = s3_valid_ff && s3_wr_ff && (s3_idx_ff == s1_idx_ff);
      s1_old    = s1_fwd ? s3_curv_ff : rdata_ff;
      // negative squared gradient counts as zero
      s1_value  = s1_sample_ff[SMP_W-1] ? '0 : s1_sample_ff[CURV_W-1:0];
      s1_weight = 17'd65536 - {1'b0, decay_ff};
      s1_p1     = 48'(decay_ff) * 48'(s1_old);
      s1_p2     = 49'(s1_weight) * 49'(s1_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_ok_ff     <= s1_ok_ff;
         s2_wr_ff     <= s1_wr;
         s2_old_ff    <= s1_old;
         s2_p1_ff     <= s1_p1;
         s2_p2_ff     <= s1_p2;
      end
   end

   // stage 2: fold result, divisor, step mode
   always_comb begin
      s2_sum   = 50'(s2_p1_ff) + 50'(s2_p2_ff);
      s2_new   = s2_sum[47:16];
      s2_neg   = s2_sample_ff[SMP_W-1];
      s2_mag   = s2_neg ? (~s2_sample_ff + 33'd1) : s2_sample_ff;
      s2_floor = {9'd0, floor_ff};
      s2_hmax  = (s2_old_ff > s2_floor) ? s2_old_ff : s2_floor;
      s2_h     = (s2_hmax == '0) ? 32'd1 : s2_hmax;
      if (s2_mag == '0) begin
         s2_mode = MODE_ZERO;
      end else if (s2_mag >= {1'b0, s2_h}) begin
         s2_mode = MODE_SAT;
      end else begin
         s2_mode = MODE_DIV;
      end
      if (!s2_ok_ff) begin
         s2_curv = '0;
      end else if (s2_kind_ff == KIND_FOLD) begin
         s2_curv = s2_new;
      end else begin
         s2_curv = s2_old_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_idx_ff  <= s2_idx_ff;
         s3_wr_ff   <= s2_wr_ff;
         s3_ok_ff   <= s2_ok_ff;
         s3_kind_ff <= s2_kind_ff;
         s3_curv_ff <= s2_curv;
         s3_neg_ff  <= s2_neg;
         s3_mode_ff <= s2_mode;
         s3_mag_ff  <= s2_mag[CURV_W-1:0];
         s3_h_ff    <= s2_h;
      end
   end

   // stage 3: lr times momentum magnitude, registered in the divider
   always_comb begin
      s3_num = (s3_mode_ff == MODE_DIV) ?
               (64'(step_size_ff) * 64'(s3_mag_ff)) : '0;
      s3_meta.idx     = s3_idx_ff;
      s3_meta.curv    = s3_curv_ff;
      s3_meta.status  = s3_ok_ff ? STATUS_OK : STATUS_ERR;
      s3_meta.is_step = s3_ok_ff && (s3_kind_ff == KIND_STEP);
      s3_meta.neg     = s3_neg_ff;
      s3_meta.mode    = s3_mode_ff;
   end

   dccs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num),
      .in_den    (s3_h_ff),
      .in_meta   (s3_meta),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_meta  (dv_meta)
   );

   // result: sign opposite to momentum; zero unless a valid step
   always_comb begin
      case (dv_meta.mode)
         MODE_SAT: res_mag = step_size_ff;
         MODE_DIV: res_mag = dv_quo;
         default:  res_mag = '0;
      endcase
      res.idx    = dv_meta.idx;
      res.curv   = dv_meta.curv;
      res.status = dv_meta.status;
      if (!dv_meta.is_step) begin
         res.step = '0;
      end else if (dv_meta.neg) begin
         res.step = {1'b0, res_mag};
      end else begin
         res.step = 33'd0 - {1'b0, res_mag};
      end
   end

   // two output slots
   assign push = adv && dv_valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_cnt_ff <= '0;
         skid_wr_ff  <= 1'b0;
         skid_rd_ff  <= 1'b0;
      end else begin
         if (push) begin
            skid_wr_ff <= !skid_wr_ff;
         end
         if (pop) begin
            skid_rd_ff <= !skid_rd_ff;
         end
         if (push && !pop) begin
            skid_cnt_ff <= skid_cnt_ff + 2'd1;
         end else if (pop && !push) begin
            skid_cnt_ff <= skid_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         skid_ff[skid_wr_ff] <= res;
      end
   end

   assign rsp_chan.valid      = (skid_cnt_ff != 2'd0);
   assign rsp_chan.index_echo = skid_ff[skid_rd_ff].idx;
   assign rsp_chan.step_value = skid_ff[skid_rd_ff].step;
   assign rsp_chan.curvature  = skid_ff[skid_rd_ff].curv;
   assign rsp_chan.status     = skid_ff[skid_rd_ff].status;

   // checks
   `ASSERT_IMPLIES(a_no_item_in_clear, clock, reset, clr_busy_ff, !req_acc, "item taken during clear")
   `ASSERT_ALWAYS(a_no_read_after_pending_fold, clock, reset, !(s1_valid_ff && s2_valid_ff && s2_wr_ff && (s1_idx_ff == s2_idx_ff)), "read overlaps unwritten fold")
   `ASSERT_IMPLIES(a_err_result_zero, clock, reset, rsp_chan.valid && rsp_chan.status, (rsp_chan.step_value == '0) && (rsp_chan.curvature == '0), "error result not zero")
   `ASSERT_ALWAYS(a_slots_no_overflow, clock, reset, skid_cnt_ff != 2'd3, "output slot overrun")

endmodule

`default_nettype wire
